### design/sorted_priority_queue_macros.svh
// Assertion macros for the sorted priority queue.
// Each check is clocked on clk and disabled while rst_n is low.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF

`define SPQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPQ_ASSERT_IMPL(label, ante, cons, msg)

`define SPQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### design/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    localparam int ValueWidth = 32;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_DEQ_EMPTY  = 2'd1;
    localparam logic [1:0] ST_ENQ_FULL   = 2'd2;

    typedef struct packed {
        logic signed [ValueWidth-1:0] priority_f;
        logic signed [ValueWidth-1:0] value_f;
    } entry_t;

    // enq and deq are already gated by full and empty
    typedef struct packed {
        logic enq;
        logic deq;
    } ctrl_t;

endpackage

### design/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell
(
    input  logic           clk,
    input  spq_pkg::ctrl_t ctrl,
    input  logic           occupied,
    input  spq_pkg::entry_t new_entry,
    input  spq_pkg::entry_t left_entry,
    input  logic           left_above,
    input  spq_pkg::entry_t right_entry,
    output spq_pkg::entry_t entry,
    output spq_pkg::entry_t entry_next,
    output logic           above
);
    import spq_pkg::*;

    entry_t entry_reg;

    assign entry = entry_reg;

    // this cell stays ahead of the new item
    assign above = occupied &&
                   ((entry_reg.priority_f > new_entry.priority_f) ||
                    ((entry_reg.priority_f == new_entry.priority_f) &&
                     (entry_reg.value_f > new_entry.value_f)));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.enq)
        begin
            if (above)
            begin
                entry_next = entry_reg;
            end
            else if (left_above)
            begin
                entry_next = new_entry;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### design/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Channel | Direction | Signals                          | Item
// s       | in        | s_tvalid s_tready s_tdata s_tuser | one enqueue or dequeue
// m       | out       | m_tvalid m_tready m_tdata         | one result per item
//
// All cells compare against the new item and shift toward their neighbor in the
// same edge, so one item per cycle while s_tready is high.
// The result sits in an output register; s_tready drops only while that
// register holds a result that m_tready has not taken.
// Reset clears the fill count and the output valid; cell contents are
// left as they are and are read only after they are written.

module sorted_priority_queue
#(
    parameter int CAPACITY = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,   // item_value[31:0], item_priority[63:32]
    input  logic          s_tuser,   // op[0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata    // removed_value[31:0], head_value[63:32],
                                     // head_priority[95:64], occupancy[100:96],
                                     // is_empty[101], status[103:102]
);
    import spq_pkg::*;

    `include "sorted_priority_queue_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg;
    logic [103:0]  out_data_reg;

    logic          accept;
    logic          full, empty;
    ctrl_t         ctrl;
    entry_t        new_entry;
    entry_t        cell_entry [CAPACITY];
    entry_t        cell_next  [CAPACITY];
    logic          cell_above [CAPACITY];
    logic [1:0]    status;
    logic signed [31:0] removed;
    logic [CW+4:0] count_ext;
    logic          empty_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);

    assign new_entry.value_f    = s_tdata[31:0];
    assign new_entry.priority_f = s_tdata[63:32];

    assign ctrl.enq = accept && (s_tuser == OP_ENQ) && !full;
    assign ctrl.deq = accept && (s_tuser == OP_DEQ) && !empty;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_a;
            if (i == 0)
            begin : g_first
                assign left_e = new_entry;
                assign left_a = 1'b1;
            end
            else
            begin : g_mid
                assign left_e = cell_entry[i-1];
                assign left_a = cell_above[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign right_e = cell_entry[i];
            end
            else
            begin : g_inner
                assign right_e = cell_entry[i+1];
            end
            spq_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (count_reg > CW'(i)),
                .new_entry  (new_entry),
                .left_entry (left_e),
                .left_above (left_a),
                .right_entry(right_e),
                .entry      (cell_entry[i]),
                .entry_next (cell_next[i]),
                .above      (cell_above[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        status = ST_OK;
        if (s_tuser == OP_ENQ && full)
        begin
            status = ST_ENQ_FULL;
        end
        else if (s_tuser == OP_DEQ && empty)
        begin
            status = ST_DEQ_EMPTY;
        end
    end

    assign removed    = ctrl.deq ? cell_entry[0].value_f : 32'sd0;
    assign empty_next = (count_next == '0);
    assign count_ext  = {5'b0, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {status,
                             empty_next,
                             count_ext[4:0],
                             empty_next ? 32'd0 : cell_next[0].priority_f,
                             empty_next ? 32'd0 : cell_next[0].value_f,
                             removed};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `SPQ_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY), "fill count above capacity")
    `SPQ_ASSERT_NEXT(a_full_drop, accept && s_tuser == OP_ENQ && full, $stable(count_reg) && m_tdata[103:102] == ST_ENQ_FULL, "enqueue on full not dropped")
    `SPQ_ASSERT_NEXT(a_empty_deq, accept && s_tuser == OP_DEQ && empty, count_reg == '0 && m_tdata[103:102] == ST_DEQ_EMPTY, "dequeue on empty not flagged")
    `SPQ_ASSERT_NEXT(a_result_shown, accept, m_tvalid && m_tdata[101] == (count_reg == '0), "result missing or empty flag off")

endmodule
